// ===== src/valid_2d_convolution_defines.svh =====
`ifndef VALID_2D_CONVOLUTION_DEFINES_SVH
`define VALID_2D_CONVOLUTION_DEFINES_SVH

// Immediate implication, sampled on the rising edge, quiet while in reset.
`define VCONV_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vconv check failed");

// Implication whose consequent is checked in the next cycle.
`define VCONV_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vconv check failed");

`endif

// ===== src/vconv_pkg.sv =====
`timescale 1ns / 1ps

package vconv_pkg;

  localparam int SUM_W     = 38;
  localparam int POS_W     = 3;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] RST_IMAGE_ROWS  = 4'd8;
  localparam logic [CFG_W-1:0] RST_IMAGE_COLS  = 4'd8;
  localparam logic [CFG_W-1:0] RST_KERNEL_ROWS = 4'd3;
  localparam logic [CFG_W-1:0] RST_KERNEL_COLS = 4'd3;

  localparam logic REQ_KERNEL = 1'b0;
  localparam logic REQ_IMAGE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_ROWS  = 2'd0,
    CFG_IMAGE_COLS  = 2'd1,
    CFG_KERNEL_ROWS = 2'd2,
    CFG_KERNEL_COLS = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic img_last;
    logic too_big;
    logic tap_last;
    logic win_last;
    logic acc_done;
    logic out_free;
  } sts_t;

endpackage

// ===== src/valid_2d_convolution.sv =====
`timescale 1ns / 1ps

// Valid-region 2D cross-correlation of an image (up to MAX_ROWS x MAX_COLS) with a kernel
// (up to MAX_KROWS x MAX_KCOLS), both loaded one signed word per transfer in raster order.
// in_req_type selects the store; the kernel pointer wraps, so a kernel stays loaded across
// images. The transfer of the final image sample starts a walk over all window positions,
// during which in_stall stays high: one shared multiply-accumulate reads one image/kernel
// pair per cycle while issuing, so each window reads kernel_rows*kernel_cols pairs, which pass
// through the memory read, product and accumulate registers before the emit, which waits if
// the output side stalls. Results come out in raster order with last set on the final one;
// a kernel larger than the image yields a single result with valid_window low.
module valid_2d_convolution #(
  parameter int MAX_ROWS    = 8,
  parameter int MAX_COLS    = 8,
  parameter int MAX_KROWS   = 8,
  parameter int MAX_KCOLS   = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [vconv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vconv_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_req_type,
  input  logic signed [15:0]                   in_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [vconv_pkg::SUM_W-1:0]   out_sum,
  output logic [vconv_pkg::POS_W-1:0]          out_row,
  output logic [vconv_pkg::POS_W-1:0]          out_col,
  output logic                                 out_valid_window,
  output logic                                 out_last
);

  vconv_pkg::cmd_t cmd;
  vconv_pkg::sts_t sts;

  vconv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vconv_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .MAX_KROWS   (MAX_KROWS),
    .MAX_KCOLS   (MAX_KCOLS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req_type      (in_req_type),
    .in_sample        (in_sample),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_sum          (out_sum),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_valid_window (out_valid_window),
    .out_last         (out_last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

// ===== src/vconv_ctrl.sv =====
`timescale 1ns / 1ps

module vconv_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  vconv_pkg::sts_t  sts,
  output vconv_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid && sts.img_last) begin
          if (sts.too_big) begin
            state_nxt = S_EMIT;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        cmd.step = 1'b1;
        if (sts.tap_last) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if ((sts.too_big || sts.acc_done) && sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.too_big || sts.win_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/vconv_dp.sv =====
`timescale 1ns / 1ps
`include "valid_2d_convolution_defines.svh"

module vconv_dp #(
  parameter int MAX_ROWS    = 8,
  parameter int MAX_COLS    = 8,
  parameter int MAX_KROWS   = 8,
  parameter int MAX_KCOLS   = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [vconv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vconv_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 in_req_type,
  input  logic signed [15:0]                   in_sample,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic signed [vconv_pkg::SUM_W-1:0]   out_sum,
  output logic [vconv_pkg::POS_W-1:0]          out_row,
  output logic [vconv_pkg::POS_W-1:0]          out_col,
  output logic                                 out_valid_window,
  output logic                                 out_last,
  input  vconv_pkg::cmd_t                      cmd,
  output vconv_pkg::sts_t                      sts
);

  localparam int MAXD_A = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int MAXD_B = (MAX_KROWS > MAX_KCOLS) ? MAX_KROWS : MAX_KCOLS;
  localparam int MAXD   = (MAXD_A > MAXD_B) ? MAXD_A : MAXD_B;
  localparam int DW     = $clog2(MAXD + 1);
  localparam int IDEPTH = MAX_ROWS * MAX_COLS;
  localparam int KDEPTH = MAX_KROWS * MAX_KCOLS;
  localparam int ICW    = $clog2(IDEPTH + 1);
  localparam int KCW    = $clog2(KDEPTH + 1);
  localparam int IA     = (IDEPTH > 1) ? $clog2(IDEPTH) : 1;
  localparam int KA     = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int SB     = SAMPLE_BITS;
  localparam int SUM_W  = vconv_pkg::SUM_W;
  localparam int POS_W  = vconv_pkg::POS_W;

  logic [vconv_pkg::CFG_W-1:0] img_rows_r, img_cols_r, ker_rows_r, ker_cols_r;
  logic [DW-1:0]  ir, ic, kr, kc;
  logic [ICW-1:0] itotal;
  logic [KCW-1:0] ktotal;

  logic [ICW-1:0] image_count_r, image_count_nxt, iptr, iptr_inc;
  logic [KCW-1:0] kernel_count_r, kernel_count_nxt, kptr, kptr_inc;
  logic [SB-1:0]  wdata;
  logic           load_img, load_ker;

  logic [SB-1:0]  image_mem [IDEPTH];
  logic [SB-1:0]  kernel_mem [KDEPTH];

  logic [DW-1:0]  r_r, c_r, ki_r, kj_r;
  logic [ICW-1:0] win_base_r, row_base_r, iaddr_r, win_base_nxt;
  logic [KCW-1:0] kaddr_r;
  logic           kj_end, c_end;

  logic signed [SB-1:0]    img_q_r, ker_q_r;
  logic signed [2*SB-1:0]  prod_r;
  logic signed [SUM_W-1:0] acc_r, prod_ext;
  logic v1_r, first1_r, last1_r;
  logic v2_r, first2_r, last2_r;
  logic acc_done_r;

  logic                    out_valid_r;
  logic signed [SUM_W-1:0] out_sum_r;
  logic [POS_W-1:0]        out_row_r, out_col_r;
  logic                    out_win_r, out_last_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_rows_r <= vconv_pkg::RST_IMAGE_ROWS;
      img_cols_r <= vconv_pkg::RST_IMAGE_COLS;
      ker_rows_r <= vconv_pkg::RST_KERNEL_ROWS;
      ker_cols_r <= vconv_pkg::RST_KERNEL_COLS;
    end else if (cfg_we) begin
      case (cfg_index)
        vconv_pkg::CFG_IMAGE_ROWS:  img_rows_r <= cfg_data;
        vconv_pkg::CFG_IMAGE_COLS:  img_cols_r <= cfg_data;
        vconv_pkg::CFG_KERNEL_ROWS: ker_rows_r <= cfg_data;
        vconv_pkg::CFG_KERNEL_COLS: ker_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp: zero acts as one, saturate at the maximum
  assign ir = (img_rows_r == '0) ? DW'(1) :
              ((32'(img_rows_r) > MAX_ROWS) ? DW'(MAX_ROWS) : DW'(img_rows_r));
  assign ic = (img_cols_r == '0) ? DW'(1) :
              ((32'(img_cols_r) > MAX_COLS) ? DW'(MAX_COLS) : DW'(img_cols_r));
  assign kr = (ker_rows_r == '0) ? DW'(1) :
              ((32'(ker_rows_r) > MAX_KROWS) ? DW'(MAX_KROWS) : DW'(ker_rows_r));
  assign kc = (ker_cols_r == '0) ? DW'(1) :
              ((32'(ker_cols_r) > MAX_KCOLS) ? DW'(MAX_KCOLS) : DW'(ker_cols_r));

  assign itotal = ICW'(ir) * ICW'(ic);
  assign ktotal = KCW'(kr) * KCW'(kc);

  // load pointers
  assign wdata    = SB'($unsigned(in_sample));
  assign load_img = cmd.load && (in_req_type == vconv_pkg::REQ_IMAGE);
  assign load_ker = cmd.load && (in_req_type == vconv_pkg::REQ_KERNEL);

  assign iptr     = (image_count_r >= itotal) ? '0 : image_count_r;
  assign iptr_inc = iptr + ICW'(1);
  assign kptr     = (kernel_count_r >= ktotal) ? '0 : kernel_count_r;
  assign kptr_inc = kptr + KCW'(1);

  always_comb begin
    image_count_nxt  = image_count_r;
    kernel_count_nxt = kernel_count_r;
    if (load_img) begin
      image_count_nxt = (iptr_inc == itotal) ? '0 : iptr_inc;
    end
    if (load_ker) begin
      kernel_count_nxt = (kptr_inc == ktotal) ? '0 : kptr_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_count_r  <= '0;
      kernel_count_r <= '0;
    end else begin
      image_count_r  <= image_count_nxt;
      kernel_count_r <= kernel_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_img) begin
      image_mem[iptr[IA-1:0]] <= wdata;
    end
    img_q_r <= image_mem[iaddr_r[IA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load_ker) begin
      kernel_mem[kptr[KA-1:0]] <= wdata;
    end
    ker_q_r <= kernel_mem[kaddr_r[KA-1:0]];
  end

  // window walk
  assign kj_end       = (kj_r + DW'(1) == kc);
  assign c_end        = (c_r + kc == ic);
  assign win_base_nxt = c_end ? (win_base_r + ICW'(kc)) : (win_base_r + ICW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_r        <= '0;
      c_r        <= '0;
      ki_r       <= '0;
      kj_r       <= '0;
      win_base_r <= '0;
      row_base_r <= '0;
      iaddr_r    <= '0;
      kaddr_r    <= '0;
    end else if (cmd.start) begin
      r_r        <= '0;
      c_r        <= '0;
      ki_r       <= '0;
      kj_r       <= '0;
      win_base_r <= '0;
      row_base_r <= '0;
      iaddr_r    <= '0;
      kaddr_r    <= '0;
    end else if (cmd.step) begin
      kaddr_r <= kaddr_r + KCW'(1);
      if (kj_end) begin
        if (!sts.tap_last) begin
          kj_r       <= '0;
          ki_r       <= ki_r + DW'(1);
          row_base_r <= row_base_r + ICW'(ic);
          iaddr_r    <= row_base_r + ICW'(ic);
        end
      end else begin
        kj_r    <= kj_r + DW'(1);
        iaddr_r <= iaddr_r + ICW'(1);
      end
    end else if (cmd.emit) begin
      ki_r       <= '0;
      kj_r       <= '0;
      kaddr_r    <= '0;
      win_base_r <= win_base_nxt;
      row_base_r <= win_base_nxt;
      iaddr_r    <= win_base_nxt;
      if (c_end) begin
        c_r <= '0;
        r_r <= r_r + DW'(1);
      end else begin
        c_r <= c_r + DW'(1);
      end
    end
  end

  // multiply-accumulate pipeline
  always_ff @(posedge clk) begin
    prod_r <= img_q_r * ker_q_r;
  end

  assign prod_ext = SUM_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      first1_r   <= 1'b0;
      last1_r    <= 1'b0;
      v2_r       <= 1'b0;
      first2_r   <= 1'b0;
      last2_r    <= 1'b0;
      acc_done_r <= 1'b0;
    end else begin
      v1_r     <= cmd.step;
      first1_r <= (kaddr_r == '0);
      last1_r  <= sts.tap_last;
      v2_r     <= v1_r;
      first2_r <= first1_r;
      last2_r  <= last1_r;
      if (cmd.emit) begin
        acc_done_r <= 1'b0;
      end else if (v2_r && last2_r) begin
        acc_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_r <= first2_r ? prod_ext : (acc_r + prod_ext);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (sts.too_big) begin
        out_sum_r  <= '0;
        out_row_r  <= '0;
        out_col_r  <= '0;
        out_win_r  <= 1'b0;
        out_last_r <= 1'b1;
      end else begin
        out_sum_r  <= acc_r;
        out_row_r  <= POS_W'(r_r);
        out_col_r  <= POS_W'(c_r);
        out_win_r  <= 1'b1;
        out_last_r <= sts.win_last;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sum          = out_sum_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_valid_window = out_win_r;
  assign out_last         = out_last_r;

  assign sts.img_last = (in_req_type == vconv_pkg::REQ_IMAGE) && (iptr_inc == itotal);
  assign sts.too_big  = (kr > ir) || (kc > ic);
  assign sts.tap_last = kj_end && (ki_r + DW'(1) == kr);
  assign sts.win_last = c_end && (r_r + kr == ir);
  assign sts.acc_done = acc_done_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  `VCONV_ASSERT_NOW(a_emit_slot_free, cmd.emit, !out_valid_r || !out_stall)
  `VCONV_ASSERT_NOW(a_done_drained, acc_done_r, !v1_r && !v2_r)
  `VCONV_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid_r)

endmodule
